>>> rtl/bbi_pkg.sv
package bbi_pkg;

  // Default geometry limits of the bit matrix.
  localparam int unsigned MaxRowsDefault    = 256;
  localparam int unsigned MaxColumnsDefault = 256;

  // Register file geometry.
  localparam int unsigned CfgWidth    = 9;
  localparam int unsigned BsWidth     = 2 * CfgWidth;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned AddrWidth   = 3;
  localparam int unsigned RegIndexBit = 2;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitIdxWidth = $clog2(BitsPerByte);

  localparam logic [CfgWidth-1:0] DimReset = CfgWidth'(2);
  localparam logic [CfgWidth-1:0] DimMin   = CfgWidth'(2);

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_PULL = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED  = 2'd0,
    STATUS_REFUSED   = 2'd1,
    STATUS_DELIVERED = 2'd2,
    STATUS_NONE      = 2'd3
  } status_e;

  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_PUSH,
    ENG_PULL,
    ENG_FINISH
  } eng_state_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Effective geometry and the restart strobe handed from the register block.
  typedef struct packed {
    logic [CfgWidth-1:0] rows;
    logic [CfgWidth-1:0] cols;
    logic [BsWidth-1:0]  bs;
    logic                restart;
  } cfg_t;

endpackage

>>> rtl/bbi_if.sv
interface bbi_in_if ();
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output func, output data_byte, output end_of_data,
                  input ready);
  modport sink (input valid, input func, input data_byte, input end_of_data,
                output ready);
endinterface

interface bbi_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output status, output out_byte, output out_last,
                  input ready);
  modport sink (input valid, input status, input out_byte, input out_last,
                output ready);
endinterface

>>> rtl/bbi_ram.sv
module bbi_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bbi_cfg.sv
module bbi_cfg import bbi_pkg::*; #(
  parameter int unsigned MAX_ROWS    = MaxRowsDefault,
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  localparam logic [CfgWidth-1:0] RowsMax = CfgWidth'(MAX_ROWS);
  localparam logic [CfgWidth-1:0] ColsMax = CfgWidth'(MAX_COLUMNS);

  function automatic logic [CfgWidth-1:0] clamp_dim(input logic [CfgWidth-1:0] v,
                                                    input logic [CfgWidth-1:0] maxv);
    logic [CfgWidth-1:0] r;
    if (v < DimMin) begin
      r = DimMin;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CfgWidth-1:0] rows_q, rows_d;
  logic [CfgWidth-1:0] cols_q, cols_d;
  logic [BsWidth-1:0]  bs_q, bs_d;
  logic [BsWidth-1:0]  rows_ext, cols_ext;
  logic                wr_en;
  reg_e                reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[RegIndexBit]);

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_ROW_COUNT:    rows_d = pwdata[CfgWidth-1:0];
        REG_COLUMN_COUNT: cols_d = pwdata[CfgWidth-1:0];
        default:          rows_d = rows_q;
      endcase
    end
  end

  // The block size follows the new register values, so it is settled by the
  // time the first item after a write reaches the engine.
  assign rows_ext = BsWidth'(clamp_dim(rows_d, RowsMax));
  assign cols_ext = BsWidth'(clamp_dim(cols_d, ColsMax));
  assign bs_d     = rows_ext * cols_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimReset;
      cols_q <= DimReset;
      bs_q   <= BsWidth'(DimReset) * BsWidth'(DimReset);
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      bs_q   <= bs_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROW_COUNT:    prdata = DataWidth'(rows_q);
      REG_COLUMN_COUNT: prdata = DataWidth'(cols_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.rows    = clamp_dim(rows_q, RowsMax);
  assign cfg_o.cols    = clamp_dim(cols_q, ColsMax);
  assign cfg_o.bs      = bs_q;
  assign cfg_o.restart = wr_en;

endmodule

>>> rtl/bit_block_interleaver.sv
// Bit-level row-column block interleaver. Each input transaction is either a
// push of one byte (func 0) or a pull of one interleaved byte (func 1), and
// each gives exactly one result transaction, in order. Pushed bits, least
// significant first, fill a row_count x column_count matrix row by row in one
// of two ping-pong banks; pulls read full banks column by column and pack
// eight bits per byte, first bit in bit 0. The matrix lives in a single
// one-bit-wide RAM with one write and one registered read port. A push is
// taken from the input buffer and then written one bit at a time; a pull of
// n bits is taken, makes its n reads in turn, and ends when the last datum
// leaves the registered read port. A refused push or an empty pull is
// answered as it is taken. A finished result waits in the engine while the
// output register is still occupied, so stalls on the result side hold up
// the engine. An input buffer and an output register let a new transaction
// arrive while the previous one is still being worked on or waits to be
// taken. Zero padding on end_of_data writes nothing to the RAM: the start of
// the padded region is recorded per bank and reads behind it return zero.
// There is no clearing pass after reset. Writing a geometry register over the
// APB-style port restarts the stream; do this only while no transaction is
// in flight.
module bit_block_interleaver import bbi_pkg::*; #(
  parameter int unsigned MAX_ROWS    = MaxRowsDefault,
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bbi_in_if.sink               in_ch,
  bbi_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  localparam int unsigned RW       = $clog2(MAX_ROWS);
  localparam int unsigned CW       = $clog2(MAX_COLUMNS);
  localparam int unsigned BankSize = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned Depth    = 2 * BankSize;
  localparam int unsigned AW       = $clog2(Depth);
  localparam int unsigned BSW      = $clog2(BankSize + 1);
  localparam int unsigned AVW      = $clog2(Depth + 1);
  localparam int unsigned CntW     = BitIdxWidth + 1;

  localparam logic [BitIdxWidth-1:0] LastBit = BitIdxWidth'(BitsPerByte - 1);

  function automatic logic [AW-1:0] bit_addr(input logic bank, input logic [RW-1:0] r,
                                             input logic [CW-1:0] c);
    return AW'(bank) * AW'(BankSize) + AW'(r) * AW'(MAX_COLUMNS) + AW'(c);
  endfunction

  // Register block: geometry, block size and restart strobe.
  cfg_t cfg;

  bbi_cfg #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  logic [BSW-1:0] bs;
  assign bs = cfg.bs[BSW-1:0];

  // Input buffer.
  logic     inb_valid_q, inb_valid_d;
  in_item_t inb_q, inb_d;
  in_item_t in_item;

  assign in_item.func        = func_e'(in_ch.func);
  assign in_item.data_byte   = in_ch.data_byte;
  assign in_item.end_of_data = in_ch.end_of_data;
  assign in_ch.ready         = !inb_valid_q;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      out_free;

  assign out_free        = !out_valid_q || out_ch.ready;
  assign out_ch.valid    = out_valid_q;
  assign out_ch.status   = out_q.status;
  assign out_ch.out_byte = out_q.out_byte;
  assign out_ch.out_last = out_q.out_last;

  // Engine state.
  eng_state_e state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  in_item_t               item_q, item_d;
  logic [BitIdxWidth-1:0] nlast_q, nlast_d;
  logic                   last_q, last_d;
  logic [7:0]             byte_q, byte_d;
  out_item_t              res_q, res_d;

  // Stream pointers and bank bookkeeping.
  logic [RW-1:0]  wr_q, wr_d, rr_q, rr_d;
  logic [CW-1:0]  wc_q, wc_d, rc_q, rc_d;
  logic           wb_q, wb_d, rb_q, rb_d;
  logic [BSW-1:0] wlin_q, wlin_d;
  logic [1:0]     full_q, full_d;
  logic [1:0]     pad_q, pad_d;
  logic [RW-1:0]  prow_q [2];
  logic [RW-1:0]  prow_d [2];
  logic [CW-1:0]  pcol_q [2];
  logic [CW-1:0]  pcol_d [2];
  logic           ended_q, ended_d;
  logic [AVW-1:0] avail_q, avail_d;

  // Read pipeline: one datum in flight from the RAM.
  logic                   rd_pend_q, rd_pend_d;
  logic [BitIdxWidth-1:0] rd_pos_q, rd_pos_d;
  logic                   rd_zero_q, rd_zero_d;

  // Memory port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic          ram_wdata, ram_rdata;

  bbi_ram #(
    .WIDTH(1),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Pointer wrap tests and the padding window of the bank being read.
  logic          wc_last, wr_last, rr_last, rc_last;
  logic          push_refused, rem_small;
  logic          pad_sel;
  logic [RW-1:0] prow_sel;
  logic [CW-1:0] pcol_sel;
  logic          pad_hit;
  logic          take, emit;
  out_item_t     emit_item;
  out_item_t     accepted_item;

  assign wc_last = (CfgWidth'(wc_q) + CfgWidth'(1)) >= cfg.cols;
  assign wr_last = (CfgWidth'(wr_q) + CfgWidth'(1)) >= cfg.rows;
  assign rr_last = (CfgWidth'(rr_q) + CfgWidth'(1)) >= cfg.rows;
  assign rc_last = (CfgWidth'(rc_q) + CfgWidth'(1)) >= cfg.cols;

  // Fewer than eight free bits left in the write bank.
  assign rem_small    = (AVW'(wlin_q) + AVW'(BitsPerByte)) > AVW'(bs);
  assign push_refused = ended_q || full_q[wb_q] || (rem_small && full_q[~wb_q]);

  assign pad_sel  = rb_q ? pad_q[1] : pad_q[0];
  assign prow_sel = rb_q ? prow_q[1] : prow_q[0];
  assign pcol_sel = rb_q ? pcol_q[1] : pcol_q[0];
  // Row-major position at or beyond the start of the padding reads as zero.
  assign pad_hit  = pad_sel && ((rr_q > prow_sel) || ((rr_q == prow_sel) && (rc_q >= pcol_sel)));

  assign accepted_item = '{status: STATUS_ACCEPTED, out_byte: 8'h00, out_last: 1'b0};

  assign ram_waddr = bit_addr(wb_q, wr_q, wc_q);
  assign ram_wdata = item_q.data_byte[cnt_q[BitIdxWidth-1:0]];
  assign ram_raddr = bit_addr(rb_q, rr_q, rc_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    item_d    = item_q;
    nlast_d   = nlast_q;
    last_d    = last_q;
    byte_d    = byte_q;
    res_d     = res_q;
    wr_d      = wr_q;
    wc_d      = wc_q;
    wb_d      = wb_q;
    wlin_d    = wlin_q;
    rr_d      = rr_q;
    rc_d      = rc_q;
    rb_d      = rb_q;
    full_d    = full_q;
    pad_d     = pad_q;
    prow_d    = prow_q;
    pcol_d    = pcol_q;
    ended_d   = ended_q;
    avail_d   = avail_q;
    rd_pend_d = 1'b0;
    rd_pos_d  = rd_pos_q;
    rd_zero_d = rd_zero_q;
    ram_we    = 1'b0;
    take      = 1'b0;
    emit      = 1'b0;
    emit_item = accepted_item;

    unique case (state_q)
      ENG_IDLE: begin
        if (inb_valid_q) begin
          if (inb_q.func == FUNC_PUSH) begin
            if (push_refused) begin
              if (out_free) begin
                take             = 1'b1;
                emit             = 1'b1;
                emit_item.status = STATUS_REFUSED;
              end
            end else begin
              take    = 1'b1;
              item_d  = inb_q;
              cnt_d   = '0;
              state_d = ENG_PUSH;
            end
          end else begin
            priority if (avail_q >= AVW'(BitsPerByte)) begin
              take    = 1'b1;
              nlast_d = LastBit;
              last_d  = ended_q && (avail_q == AVW'(BitsPerByte));
            end else if ((avail_q != '0) && ended_q) begin
              take    = 1'b1;
              nlast_d = avail_q[BitIdxWidth-1:0] - BitIdxWidth'(1);
              last_d  = 1'b1;
            end else if (out_free) begin
              take             = 1'b1;
              emit             = 1'b1;
              emit_item.status = STATUS_NONE;
            end else begin
              // Nothing to deliver and the output register is still occupied.
              take = 1'b0;
            end
            if (take && !emit) begin
              cnt_d   = '0;
              byte_d  = '0;
              state_d = ENG_PULL;
              if (last_d) begin
                ended_d = 1'b0;
              end
            end
          end
        end
      end

      ENG_PUSH: begin
        if (!full_q[wb_q]) begin
          ram_we = 1'b1;
          if (wc_last) begin
            wc_d = '0;
            if (wr_last) begin
              wr_d         = '0;
              wlin_d       = '0;
              full_d[wb_q] = 1'b1;
              avail_d      = avail_d + AVW'(bs);
              wb_d         = ~wb_q;
            end else begin
              wr_d   = wr_q + RW'(1);
              wlin_d = wlin_q + BSW'(1);
            end
          end else begin
            wc_d   = wc_q + CW'(1);
            wlin_d = wlin_q + BSW'(1);
          end
        end
        if (cnt_q[BitIdxWidth-1:0] == LastBit) begin
          if (item_q.end_of_data) begin
            // Close a partly written block: the rest of it counts as zero bits.
            if (((wr_d != '0) || (wc_d != '0)) && !full_d[wb_d]) begin
              if (wb_d) begin
                prow_d[1] = wr_d;
                pcol_d[1] = wc_d;
              end else begin
                prow_d[0] = wr_d;
                pcol_d[0] = wc_d;
              end
              pad_d[wb_d]  = 1'b1;
              full_d[wb_d] = 1'b1;
              avail_d      = avail_d + AVW'(bs);
              wb_d         = ~wb_d;
              wr_d         = '0;
              wc_d         = '0;
              wlin_d       = '0;
            end
            ended_d = 1'b1;
          end
          if (out_free) begin
            emit    = 1'b1;
            state_d = ENG_IDLE;
          end else begin
            res_d   = accepted_item;
            state_d = ENG_FINISH;
          end
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      ENG_PULL: begin
        if (cnt_q <= CntW'(nlast_q)) begin
          rd_pend_d = 1'b1;
          rd_pos_d  = cnt_q[BitIdxWidth-1:0];
          rd_zero_d = pad_hit;
          cnt_d     = cnt_q + CntW'(1);
          avail_d   = avail_q - AVW'(1);
          if (rr_last) begin
            rr_d = '0;
            if (rc_last) begin
              rc_d         = '0;
              full_d[rb_q] = 1'b0;
              pad_d[rb_q]  = 1'b0;
              rb_d         = ~rb_q;
            end else begin
              rc_d = rc_q + CW'(1);
            end
          end else begin
            rr_d = rr_q + RW'(1);
          end
        end
        if (rd_pend_q) begin
          byte_d[rd_pos_q] = ram_rdata && !rd_zero_q;
          if (rd_pos_q == nlast_q) begin
            res_d = '{status: STATUS_DELIVERED, out_byte: byte_d, out_last: last_q};
            if (out_free) begin
              emit      = 1'b1;
              emit_item = res_d;
              state_d   = ENG_IDLE;
            end else begin
              state_d = ENG_FINISH;
            end
          end
        end
      end

      ENG_FINISH: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_item = res_q;
          state_d   = ENG_IDLE;
        end
      end

      default: state_d = ENG_IDLE;
    endcase

    // A register write starts a fresh stream.
    if (cfg.restart) begin
      wr_d    = '0;
      wc_d    = '0;
      wb_d    = 1'b0;
      wlin_d  = '0;
      rr_d    = '0;
      rc_d    = '0;
      rb_d    = 1'b0;
      full_d  = '0;
      pad_d   = '0;
      ended_d = 1'b0;
      avail_d = '0;
    end
  end

  always_comb begin
    inb_valid_d = inb_valid_q;
    inb_d       = inb_q;
    if (in_ch.valid && in_ch.ready) begin
      inb_valid_d = 1'b1;
      inb_d       = in_item;
    end else if (take) begin
      inb_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inb_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      wr_q        <= '0;
      wc_q        <= '0;
      wb_q        <= 1'b0;
      wlin_q      <= '0;
      rr_q        <= '0;
      rc_q        <= '0;
      rb_q        <= 1'b0;
      full_q      <= '0;
      pad_q       <= '0;
      ended_q     <= 1'b0;
      avail_q     <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      inb_valid_q <= inb_valid_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      wr_q        <= wr_d;
      wc_q        <= wc_d;
      wb_q        <= wb_d;
      wlin_q      <= wlin_d;
      rr_q        <= rr_d;
      rc_q        <= rc_d;
      rb_q        <= rb_d;
      full_q      <= full_d;
      pad_q       <= pad_d;
      ended_q     <= ended_d;
      avail_q     <= avail_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inb_q     <= inb_d;
    out_q     <= out_d;
    item_q    <= item_d;
    nlast_q   <= nlast_d;
    last_q    <= last_d;
    byte_q    <= byte_d;
    res_q     <= res_d;
    prow_q    <= prow_d;
    pcol_q    <= pcol_d;
    rd_pos_q  <= rd_pos_d;
    rd_zero_q <= rd_zero_d;
  end

endmodule

>>> rtl/bbi_checker.sv
module bbi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_status_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // Input buffer, engine and output register each hold at most one transaction.
  localparam int unsigned MaxOutstanding = 3;

  logic       in_acc, out_acc;
  logic [2:0] outstanding_q, outstanding_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    outstanding_d = outstanding_q;
    if (in_acc && !out_acc) begin
      outstanding_d = outstanding_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      outstanding_d = outstanding_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({out_status_i, out_byte_i, out_last_i}))
    else $error("result changed or dropped while stalled");

  a_outstanding_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 3'(MaxOutstanding))
    else $error("more transactions in flight than the block can hold");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> outstanding_q != 3'd0)
    else $error("result offered with no input transaction pending");

endmodule

bind bit_block_interleaver bbi_checker u_bbi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_status_i(out_ch.status),
  .out_byte_i  (out_ch.out_byte),
  .out_last_i  (out_ch.out_last)
);

>>> tb/sv/bit_block_interleaver_test.sv
`timescale 1ns / 100ps

import bbi_pkg::*;

// Keeps its own copy of the interleaver state and the expected results, in
// transaction order.
class interleaver_scoreboard;
  logic [CfgWidth-1:0] row_reg;
  logic [CfgWidth-1:0] col_reg;
  bit                  bit_mem [2*MaxRowsDefault*MaxColumnsDefault];
  int unsigned         wr_row;
  int unsigned         wr_col;
  int unsigned         rd_row;
  int unsigned         rd_col;
  bit                  wr_bank;
  bit                  rd_bank;
  bit [1:0]            bank_full;
  bit                  data_ended;
  out_item_t           expected_results [$];
  int unsigned         mismatches;

  function new();
    row_reg    = DimReset;
    col_reg    = DimReset;
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    wr_row     = 0;
    wr_col     = 0;
    wr_bank    = 1'b0;
    rd_row     = 0;
    rd_col     = 0;
    rd_bank    = 1'b0;
    bank_full  = 2'b00;
    data_ended = 1'b0;
  endfunction

  function int unsigned clamp_dim(logic [CfgWidth-1:0] v, int unsigned maxv);
    if (v < DimMin) return 32'(DimMin);
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  function int unsigned rows();
    return clamp_dim(row_reg, MaxRowsDefault);
  endfunction

  function int unsigned cols();
    return clamp_dim(col_reg, MaxColumnsDefault);
  endfunction

  function int unsigned slot(bit bank, int unsigned r, int unsigned c);
    return int'(bank) * MaxRowsDefault * MaxColumnsDefault + r * MaxColumnsDefault + c;
  endfunction

  function void write_reg(reg_e idx, logic [DataWidth-1:0] value);
    if (idx == REG_ROW_COUNT) row_reg = value[CfgWidth-1:0];
    else col_reg = value[CfgWidth-1:0];
    restart();
  endfunction

  function void put_bit(bit b);
    if (bank_full[wr_bank]) return;
    bit_mem[slot(wr_bank, wr_row, wr_col)] = b;
    wr_col++;
    if (wr_col >= cols()) begin
      wr_col = 0;
      wr_row++;
      if (wr_row >= rows()) begin
        wr_row             = 0;
        bank_full[wr_bank] = 1'b1;
        wr_bank            = ~wr_bank;
      end
    end
  endfunction

  function bit get_bit();
    bit b;
    if (!bank_full[rd_bank]) return 1'b0;
    b = bit_mem[slot(rd_bank, rd_row, rd_col)];
    rd_row++;
    if (rd_row >= rows()) begin
      rd_row = 0;
      rd_col++;
      if (rd_col >= cols()) begin
        rd_col             = 0;
        bank_full[rd_bank] = 1'b0;
        rd_bank            = ~rd_bank;
      end
    end
    return b;
  endfunction

  function void predict(in_item_t item);
    out_item_t   res;
    int unsigned blk;
    int unsigned room;
    int unsigned avail;
    int unsigned n;
    res.status   = STATUS_ACCEPTED;
    res.out_byte = '0;
    res.out_last = 1'b0;
    blk = rows() * cols();
    if (item.func == FUNC_PUSH) begin
      room = blk - (wr_row * cols() + wr_col);
      if (data_ended || bank_full[wr_bank] ||
          (room < BitsPerByte && bank_full[~wr_bank])) begin
        res.status = STATUS_REFUSED;
      end else begin
        for (int i = 0; i < BitsPerByte; i++) put_bit(item.data_byte[i]);
        if (item.end_of_data) begin
          while ((wr_row != 0 || wr_col != 0) && !bank_full[wr_bank]) put_bit(1'b0);
          data_ended = 1'b1;
        end
      end
    end else begin
      avail = 0;
      if (bank_full[rd_bank]) begin
        avail = blk - (rd_col * rows() + rd_row);
        if (bank_full[~rd_bank]) avail += blk;
      end
      if (avail >= BitsPerByte) n = BitsPerByte;
      else if (avail > 0 && data_ended) n = avail;
      else n = 0;
      if (n == 0) begin
        res.status = STATUS_NONE;
      end else begin
        for (int i = 0; i < n; i++) res.out_byte[i] = get_bit();
        res.status = STATUS_DELIVERED;
        if (data_ended && avail == n) begin
          res.out_last = 1'b1;
          data_ended   = 1'b0;
        end
      end
    end
    expected_results.push_back(res);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result transaction with nothing expected: status %0d", got.status);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatches++;
    end
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected 0x%02h, actual 0x%02h", want.out_byte, got.out_byte);
      mismatches++;
    end
    if (got.out_last !== want.out_last) begin
      $error("out_last: expected %0d, actual %0d", want.out_last, got.out_last);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return expected_results.size();
  endfunction
endclass

module bit_block_interleaver_test;
  import bbi_pkg::*;

  localparam int unsigned HalfPeriod  = 5;
  // The slowest correct run stays far below this, with both sides stalling
  // as long as they can, plus the drain pauses.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 900;
  // Long enough for a pull of eight bits to pass through the input buffer,
  // the engine and the output register, with room to spare.
  localparam int unsigned DrainCycles = 20;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  bbi_in_if  in_ch ();
  bbi_out_if out_ch ();

  interleaver_scoreboard sb = new();

  // Longest wait each side may draw before its next transaction. The random
  // phases set these to zero now and then so that there are stretches with
  // no idling at all.
  int unsigned in_gap_max  = 5;
  int unsigned out_gap_max = 5;
  int unsigned items_sent  = 0;
  int unsigned cycles      = 0;

  bit_block_interleaver dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one input transaction after a random gap and returns once it has
  // been taken. The expectation is formed at the accepting edge, so the
  // predictor state always matches what the block has seen. A gap of zero
  // keeps valid high straight into the next transaction.
  task automatic send_item(in_item_t item);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= item.func;
    in_ch.data_byte   <= item.data_byte;
    in_ch.end_of_data <= item.end_of_data;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.predict(item);
    items_sent++;
  endtask

  task automatic push_byte(logic [7:0] data, bit eod);
    in_item_t item;
    item.func        = FUNC_PUSH;
    item.data_byte   = data;
    item.end_of_data = eod;
    send_item(item);
  endtask

  // The data and end fields carry noise on a pull; the block must ignore it.
  task automatic pull_byte();
    in_item_t item;
    item.func        = FUNC_PULL;
    item.data_byte   = 8'($urandom_range(0, 255));
    item.end_of_data = 1'($urandom_range(0, 1));
    send_item(item);
  endtask

  // Stops offering input until every expected result has been taken, then
  // lets the engine settle. Always advances time after lowering valid.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; pready is always high, so the register
  // takes the value at the access edge. Ends with the bus idle so that a
  // following write starts cleanly.
  task automatic apb_write(reg_e idx, logic [DataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWidth'(int'(idx) << RegIndexBit);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // A geometry write restarts the stream, so it is only done with the block
  // drained and idle.
  task automatic program_geometry(logic [DataWidth-1:0] rows_val,
                                  logic [DataWidth-1:0] cols_val);
    quiesce();
    apb_write(REG_ROW_COUNT, rows_val);
    apb_write(REG_COLUMN_COUNT, cols_val);
  endtask

  // One data stream: pushes with random content, pulls mixed in at a rate
  // drawn per stream, normally closed by an end flag and then drained by
  // pulls until the final byte is out. A stray end flag now and then cuts a
  // stream short, and a stream without an end flag runs into the next one.
  task automatic run_stream(int unsigned max_len);
    int unsigned n_bytes;
    int unsigned pull_pct;
    int unsigned guard;
    bit          eod;
    n_bytes  = $urandom_range(1, max_len);
    pull_pct = $urandom_range(0, 3) * 20;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      while ($urandom_range(0, 99) < pull_pct) pull_byte();
      if (i == n_bytes - 1) eod = ($urandom_range(0, 6) != 0);
      else eod = ($urandom_range(0, 39) == 0);
      push_byte(8'($urandom_range(0, 255)), eod);
      if (i == n_bytes / 2 && $urandom_range(0, 15) == 0) quiesce();
    end
    guard = 0;
    while (sb.data_ended && guard < 300) begin
      pull_byte();
      guard++;
    end
    if ($urandom_range(0, 3) == 0) pull_byte();
  endtask

  // Result side: takes each result transaction after its own random stall
  // and hands it to the scoreboard. The fields are read right after the
  // edge, before any update from that edge lands.
  initial begin : result_sink
    int unsigned gap;
    out_item_t   got;
    out_ch.ready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      got.status   = status_e'(out_ch.status);
      got.out_byte = out_ch.out_byte;
      got.out_last = out_ch.out_last;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [DataWidth-1:0] rv;
    logic [DataWidth-1:0] cv;
    int unsigned          max_len;
    int unsigned          item_goal;

    in_ch.valid       <= 1'b0;
    in_ch.func        <= FUNC_PUSH;
    in_ch.data_byte   <= '0;
    in_ch.end_of_data <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    rst_ni            <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry is 2 x 2, so a bank holds only four bits and a single
    // byte spills over into the second bank.
    pull_byte();                // nothing ready yet
    push_byte(8'hFF, 1'b0);     // fills both banks at once
    push_byte(8'h00, 1'b0);     // refused, both banks full
    push_byte(8'h00, 1'b1);     // refused, and its end flag is ignored
    pull_byte();                // one byte out of two banks
    pull_byte();                // empty again
    push_byte(8'hA5, 1'b1);     // ends exactly on a block boundary, no padding
    push_byte(8'h3C, 1'b0);     // refused, data has ended
    pull_byte();                // full-size final byte with the last flag
    pull_byte();                // nothing ready after the stream closed

    // Sender holds off until every result is back, with no register write.
    quiesce();

    // 3 x 3: sixteen bits padded to eighteen, so the final byte is short.
    program_geometry(3, 3);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    pull_byte();
    pull_byte();
    pull_byte();
    pull_byte();

    // Values below the minimum act as 2.
    program_geometry(0, 1);
    push_byte(8'h5A, 1'b1);
    pull_byte();
    pull_byte();

    // Largest matrix; the row value is above the maximum and has junk above
    // the register field. One byte is padded out to a whole bank.
    program_geometry(32'hFFFF_FFFF, 256);
    push_byte(8'h81, 1'b1);
    pull_byte();
    pull_byte();
    pull_byte();

    // One tall, narrow matrix with the most rows.
    program_geometry(256, 2);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b1);
    pull_byte();

    item_goal = items_sent + RandomItems;
    while (items_sent < item_goal) begin
      case ($urandom_range(0, 9))
        0: begin
          rv = $urandom_range(256, 511);
          cv = $urandom_range(0, 2);
        end
        1: begin
          rv = $urandom_range(0, 2);
          cv = $urandom_range(256, 511);
        end
        2: begin
          rv = $urandom_range(0, 1);
          cv = $urandom_range(0, 1);
        end
        default: begin
          rv = $urandom_range(2, 9);
          cv = $urandom_range(2, 9);
        end
      endcase
      if ($urandom_range(0, 3) == 0) rv |= $urandom() << CfgWidth;
      if ($urandom_range(0, 3) == 0) cv |= $urandom() << CfgWidth;
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 5;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      program_geometry(rv, cv);
      // Enough bytes to fill both banks and hit refusals, capped for the
      // large matrices.
      max_len = sb.rows() * sb.cols() / 4 + 3;
      if (max_len > 150) max_len = 150;
      repeat ($urandom_range(1, 4)) run_stream(max_len);
    end

    quiesce();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
